FILE: rtl/dcc_pkg.sv
// shared types, constants and calendar helpers for the day count calendar engine
package dcc_pkg;

    localparam int DAY_BITS_DEF = 20;

    localparam int CMD_W   = 2;
    localparam int AMT_W   = 20;
    localparam int SYEAR_W = 12;
    localparam int YEAR_W  = 13;
    localparam int MON_W   = 4;
    localparam int MDAY_W  = 5;
    localparam int LEN_W   = 9;

    // input word layout, lowest bit first
    localparam int AMT_LSB    = 0;
    localparam int SYEAR_LSB  = AMT_LSB + AMT_W;
    localparam int SMON_LSB   = SYEAR_LSB + SYEAR_W;
    localparam int SDAY_LSB   = SMON_LSB + MON_W;
    localparam int IN_FIELDS_W = SDAY_LSB + MDAY_W;
    localparam int IN_DATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 13'd1970;
    localparam logic [MDAY_W-1:0] MDAY_FIRST = 5'd1;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    localparam logic [LEN_W-1:0] LEN_YEAR      = 9'd365;
    localparam logic [LEN_W-1:0] LEN_LEAP_YEAR = 9'd366;
    localparam logic [LEN_W-1:0] LEN_FEB       = 9'd28;
    localparam logic [LEN_W-1:0] LEN_FEB_LEAP  = 9'd29;
    localparam logic [LEN_W-1:0] LEN_SHORT     = 9'd30;
    localparam logic [LEN_W-1:0] LEN_LONG      = 9'd31;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_DAYS   = 2'd0,
        CMD_ADD_MONTHS = 2'd1,
        CMD_ADD_YEARS  = 2'd2,
        CMD_SET_DATE   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [AMT_W-1:0]   amount;
        logic [SYEAR_W-1:0] set_year;
        logic [MON_W-1:0]   set_month;
        logic [MDAY_W-1:0]  set_day;
    } t_item;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [MDAY_W-1:0] day;
    } t_date;

    typedef struct packed {
        logic neg;
        logic zero;
        logic over;
    } t_alu_flags;

    // leap every fourth year, so only the two low year bits matter
    function automatic logic is_leap(input logic [1:0] y_lo);
        return y_lo == 2'b00;
    endfunction

    function automatic logic [LEN_W-1:0] year_len(input logic [1:0] y_lo);
        return is_leap(y_lo) ? LEN_LEAP_YEAR : LEN_YEAR;
    endfunction

    // months past december count as long months
    function automatic logic [LEN_W-1:0] month_len(input logic [1:0] y_lo,
                                                   input logic [MON_W-1:0] m);
        logic [LEN_W-1:0] len;
        case (m) inside
            MON_FEB:                            len = is_leap(y_lo) ? LEN_FEB_LEAP : LEN_FEB;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
            default:                            len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/dcc_alu.sv
// shared add/subtract unit with sign, zero and range flags
module dcc_alu
    import dcc_pkg::*;
#(
    parameter int DAY_BITS = DAY_BITS_DEF,
    parameter int ACC_W    = ((DAY_BITS > AMT_W) ? DAY_BITS : AMT_W) + 2
) (
    input  logic [ACC_W-1:0] i_a,
    input  logic [ACC_W-1:0] i_b,
    input  logic             i_sub,
    output logic [ACC_W-1:0] o_sum,
    output t_alu_flags       o_flags
);

    logic [ACC_W-1:0] b_op;

    // two's complement subtract through the carry in
    assign b_op  = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + b_op + {{(ACC_W-1){1'b0}}, i_sub};

    assign o_flags.neg  = o_sum[ACC_W-1];
    assign o_flags.zero = (o_sum == '0);
    assign o_flags.over = !o_sum[ACC_W-1] && (|o_sum[ACC_W-2:DAY_BITS]);

endmodule

FILE: rtl/dcc_seq.sv
// command sequencer, day count and decoded date state around the shared alu
module dcc_seq
    import dcc_pkg::*;
#(
    parameter int DAY_BITS = DAY_BITS_DEF,
    parameter int ACC_W    = ((DAY_BITS > AMT_W) ? DAY_BITS : AMT_W) + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_item               i_item,
    output logic                o_idle,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic                o_status,
    output logic [DAY_BITS-1:0] o_day_count,
    output t_date               o_date
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_ADD_D  = 11'b000_0000_0010,
        S_ADD_M  = 11'b000_0000_0100,
        S_ADD_Y  = 11'b000_0000_1000,
        S_SET_Y  = 11'b000_0001_0000,
        S_SET_M  = 11'b000_0010_0000,
        S_SET_D  = 11'b000_0100_0000,
        S_COMMIT = 11'b000_1000_0000,
        S_DEC_Y  = 11'b001_0000_0000,
        S_DEC_M  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state             r_state;
    logic [DAY_BITS-1:0] r_days;
    logic [YEAR_W-1:0]  r_year;
    logic [MON_W-1:0]   r_month;
    logic [MDAY_W-1:0]  r_day;
    logic               r_err;

    logic [ACC_W-1:0]   r_acc;
    logic [AMT_W-1:0]   r_amt;
    logic [YEAR_W-1:0]  r_y;
    logic [MON_W-1:0]   r_m;
    logic [SYEAR_W-1:0] r_i;
    logic [MON_W-1:0]   r_im;
    logic [SYEAR_W-1:0] r_sy;
    logic [MON_W-1:0]   r_sm;
    logic [MDAY_W-1:0]  r_sd;

    logic [ACC_W-1:0]   alu_b;
    logic               alu_sub;
    logic [ACC_W-1:0]   alu_sum;
    t_alu_flags         alu_flags;
    logic [ACC_W-1:0]   cur_ext;
    logic [1:0]         feb_year;
    logic               amt_pos;
    logic               at_end;

    assign cur_ext  = {{(ACC_W-DAY_BITS){1'b0}}, r_days};
    // the february that follows: this year up to february, else next year
    assign feb_year = (r_month > MON_FEB) ? (r_y[1:0] + 2'd1) : r_y[1:0];
    assign amt_pos  = !i_item.amount[AMT_W-1] && (i_item.amount != '0);
    assign at_end   = alu_flags.neg || alu_flags.zero;

    always_comb begin
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_ADD_D:  alu_b = {{(ACC_W-AMT_W){r_amt[AMT_W-1]}}, r_amt};
            S_ADD_M:  alu_b = {{(ACC_W-LEN_W){1'b0}}, month_len(r_y[1:0], r_m)};
            S_ADD_Y:  alu_b = {{(ACC_W-LEN_W){1'b0}}, year_len(feb_year)};
            S_SET_Y:  alu_b = {{(ACC_W-LEN_W){1'b0}}, year_len(r_i[1:0])};
            S_SET_M:  alu_b = {{(ACC_W-LEN_W){1'b0}}, month_len(r_sy[1:0], r_im)};
            S_SET_D:  alu_b = {{(ACC_W-MDAY_W){1'b0}}, r_sd};
            S_COMMIT: alu_b = {{(ACC_W-1){1'b0}}, 1'b1};
            S_DEC_Y: begin
                alu_b   = {{(ACC_W-LEN_W){1'b0}}, year_len(r_y[1:0])};
                alu_sub = 1'b1;
            end
            S_DEC_M: begin
                alu_b   = {{(ACC_W-LEN_W){1'b0}}, month_len(r_y[1:0], r_m)};
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    dcc_alu #(
        .DAY_BITS (DAY_BITS),
        .ACC_W    (ACC_W)
    ) u_alu (
        .i_a     (r_acc),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_flags (alu_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_days  <= '0;
            r_year  <= EPOCH_YEAR;
            r_month <= MON_JAN;
            r_day   <= MDAY_FIRST;
            r_err   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_amt <= i_item.amount;
                        r_sy  <= i_item.set_year;
                        r_sm  <= i_item.set_month;
                        r_sd  <= i_item.set_day;
                        r_acc <= cur_ext;
                        r_y   <= r_year;
                        r_m   <= r_month;
                        r_i   <= EPOCH_YEAR[SYEAR_W-1:0];
                        r_im  <= MON_JAN;
                        r_err <= 1'b0;
                        unique case (i_item.cmd)
                            CMD_ADD_DAYS:   r_state <= S_ADD_D;
                            CMD_ADD_MONTHS: r_state <= amt_pos ? S_ADD_M : S_COMMIT;
                            CMD_ADD_YEARS:  r_state <= amt_pos ? S_ADD_Y : S_COMMIT;
                            CMD_SET_DATE: begin
                                r_acc   <= '1;
                                r_state <= S_SET_Y;
                            end
                            default:        r_state <= S_COMMIT;
                        endcase
                    end
                end
                S_ADD_D: begin
                    r_acc   <= alu_sum;
                    r_err   <= alu_flags.neg || alu_flags.over;
                    r_state <= S_COMMIT;
                end
                S_ADD_M: begin
                    r_acc <= alu_sum;
                    r_amt <= r_amt - 1'b1;
                    if (r_m == MON_DEC) begin
                        r_m <= MON_JAN;
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_m <= r_m + 1'b1;
                    end
                    if (alu_flags.over) begin
                        r_err   <= 1'b1;
                        r_state <= S_COMMIT;
                    end else if (r_amt == {{(AMT_W-1){1'b0}}, 1'b1}) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_ADD_Y: begin
                    r_acc <= alu_sum;
                    r_amt <= r_amt - 1'b1;
                    r_y   <= r_y + 1'b1;
                    if (alu_flags.over) begin
                        r_err   <= 1'b1;
                        r_state <= S_COMMIT;
                    end else if (r_amt == {{(AMT_W-1){1'b0}}, 1'b1}) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_SET_Y: begin
                    if (r_i < r_sy) begin
                        r_acc <= alu_sum;
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_state <= S_SET_M;
                    end
                end
                S_SET_M: begin
                    if (r_im < r_sm) begin
                        r_acc <= alu_sum;
                        r_im  <= r_im + 1'b1;
                    end else begin
                        r_state <= S_SET_D;
                    end
                end
                S_SET_D: begin
                    r_acc   <= alu_sum;
                    r_err   <= alu_flags.neg || alu_flags.over;
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (!r_err && (r_acc != cur_ext)) begin
                        // take the new count and decode from day one of the epoch
                        r_days  <= r_acc[DAY_BITS-1:0];
                        r_acc   <= alu_sum;
                        r_y     <= EPOCH_YEAR;
                        r_m     <= MON_JAN;
                        r_state <= S_DEC_Y;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DEC_Y: begin
                    if (at_end) begin
                        r_state <= S_DEC_M;
                    end else begin
                        r_acc <= alu_sum;
                        r_y   <= r_y + 1'b1;
                    end
                end
                S_DEC_M: begin
                    if (at_end || (r_m >= MON_DEC)) begin
                        r_year  <= r_y;
                        r_month <= r_m;
                        r_day   <= r_acc[MDAY_W-1:0];
                        r_state <= S_DONE;
                    end else begin
                        r_acc <= alu_sum;
                        r_m   <= r_m + 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_status     = r_err;
    assign o_day_count  = r_days;
    assign o_date.year  = r_year;
    assign o_date.month = r_month;
    assign o_date.day   = r_day;

endmodule

FILE: rtl/day_count_calendar_engine_unit.sv
// top level of the day count calendar engine: stream ports, output register, checks
//
//  channel  | direction | word contents
//  ---------+-----------+-----------------------------------------------------------
//  s        | in        | tuser: command; tdata: amount, set_year, set_month, set_day
//  m        | out       | tuser: status;  tdata: day_count, year, month, day
//
// one command word at a time: s tready is high only while the sequencer idles
// add days adds the amount once; add months or years add a month or year
// length per step; set sums the years from 1970, then the months, then the day
// a changed count adds a decode through the shared adder, by years and then months
// the result word waits in an output register while a new word is taken; a further
// result waits in the sequencer until it frees; reset gives count 0 and 1970-01-01
module day_count_calendar_engine_unit
    import dcc_pkg::*;
#(
    parameter int DAY_BITS = DAY_BITS_DEF,
    localparam int ACC_W        = ((DAY_BITS > AMT_W) ? DAY_BITS : AMT_W) + 2,
    localparam int OUT_FIELDS_W = DAY_BITS + YEAR_W + MON_W + MDAY_W,
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // amount, set_year, set_month, set_day, zero padding
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // command
    input  logic [CMD_W-1:0]      i_s_tuser,

    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // day_count, year, month, day, zero padding
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // status
    output logic [0:0]            o_m_tuser
);

    t_item               item;
    logic                s_accept;
    logic                seq_idle;
    logic                res_valid;
    logic                res_ready;
    logic                res_status;
    logic [DAY_BITS-1:0] res_days;
    t_date               res_date;
    logic [OUT_DATA_W-1:0] res_word;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [0:0]            r_m_user;

    // unpack the command word
    assign item.cmd       = t_cmd'(i_s_tuser);
    assign item.amount    = i_s_tdata[AMT_LSB +: AMT_W];
    assign item.set_year  = i_s_tdata[SYEAR_LSB +: SYEAR_W];
    assign item.set_month = i_s_tdata[SMON_LSB +: MON_W];
    assign item.set_day   = i_s_tdata[SDAY_LSB +: MDAY_W];

    assign o_s_tready = seq_idle;
    assign s_accept   = i_s_tvalid && seq_idle;

    dcc_seq #(
        .DAY_BITS (DAY_BITS),
        .ACC_W    (ACC_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_accept),
        .i_item      (item),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_status    (res_status),
        .o_day_count (res_days),
        .o_date      (res_date)
    );

    // result packing, day count in the low bits
    always_comb begin
        res_word = '0;
        res_word[OUT_FIELDS_W-1:0] = {res_date.day, res_date.month, res_date.year, res_days};
    end

    // output register frees as its word is taken
    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_data <= res_word;
            r_m_user <= res_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // a taken command word closes the input until its result is handed on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("input still ready after a command word was taken");

    // the sequencer never offers a result while it is open for a new command
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_idle |-> !res_valid)
        else $error("result pending while sequencer idle");

    // every delivered date has a real month and a non-zero day
    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            (o_m_tdata[DAY_BITS+YEAR_W +: MON_W] != '0) &&
            (o_m_tdata[DAY_BITS+YEAR_W +: MON_W] <= MON_DEC) &&
            (o_m_tdata[DAY_BITS+YEAR_W+MON_W +: MDAY_W] != '0))
        else $error("decoded date out of calendar range");

endmodule

FILE: verif/testbench.sv
// self-checking stream testbench for the day count calendar engine
`timescale 1ns / 100ps

module testbench;
    import dcc_pkg::*;

    localparam int DAY_BITS   = DAY_BITS_DEF;
    localparam int RES_W      = ((DAY_BITS + YEAR_W + MON_W + MDAY_W + 7) / 8) * 8;
    localparam int YEAR_LSB   = DAY_BITS;
    localparam int MON_LSB    = YEAR_LSB + YEAR_W;
    localparam int MDAY_LSB   = MON_LSB + MON_W;
    localparam longint MAX_COUNT = (longint'(1) << DAY_BITS) - 1;
    // longest quiet stretch: a huge month step from the epoch plus a full decode
    localparam int QUIET_LIMIT = 200000;

    typedef struct packed {
        logic                status;
        logic [DAY_BITS-1:0] count;
        logic [YEAR_W-1:0]   year;
        logic [MON_W-1:0]    month;
        logic [MDAY_W-1:0]   day;
    } t_day_result;

    // predicts the calendar result of every accepted command word
    class calendar_scoreboard;
        longint      count = 0;
        int          cur_year = 1970;
        int          cur_month = 1;
        int          cur_day = 1;
        int          fail_count = 0;
        t_day_result expected_q[$];

        function bit leap_yr(int y);
            return (y & 3) == 0;
        endfunction

        function int month_days(int y, int m);
            case (m) inside
                2:           return leap_yr(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function void decode_count();
            longint n;
            n = count + 1;
            cur_year  = 1970;
            cur_month = 1;
            while (n > (leap_yr(cur_year) ? 366 : 365)) begin
                n -= leap_yr(cur_year) ? 366 : 365;
                cur_year++;
            end
            while (cur_month < 12 && n > month_days(cur_year, cur_month)) begin
                n -= month_days(cur_year, cur_month);
                cur_month++;
            end
            cur_day = int'(n);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_command(t_item it);
            longint      nxt, base, off;
            int          amt, y, m, i, sy, sm;
            bit          err;
            bit          lp;
            t_day_result res;
            nxt = count;
            err = 1'b0;
            amt = $signed(it.amount);
            sy  = it.set_year;
            sm  = it.set_month;
            case (it.cmd)
                CMD_ADD_DAYS: begin
                    nxt = count + amt;
                    err = (nxt < 0) || (nxt > MAX_COUNT);
                end
                CMD_ADD_MONTHS: begin
                    // step from the first of the month, then put the day offset back
                    off = cur_day - 1;
                    base = count - off;
                    y = cur_year;
                    m = cur_month;
                    while (amt > 0) begin
                        base += month_days(y, m);
                        m++;
                        if (m > 12) begin
                            m = 1;
                            y++;
                        end
                        if (base + off > MAX_COUNT) begin
                            err = 1'b1;
                            break;
                        end
                        amt--;
                    end
                    nxt = base + off;
                end
                CMD_ADD_YEARS: begin
                    // the february that each step crosses decides its length
                    y = cur_year;
                    while (amt > 0) begin
                        lp = (cur_month > 2) ? leap_yr(y + 1) : leap_yr(y);
                        nxt += lp ? 366 : 365;
                        y++;
                        if (nxt > MAX_COUNT) begin
                            err = 1'b1;
                            break;
                        end
                        amt--;
                    end
                end
                default: begin
                    nxt = -1;
                    for (i = 1970; i < sy; i++) nxt += leap_yr(i) ? 366 : 365;
                    for (i = 1; i < sm; i++) nxt += month_days(sy, i);
                    nxt += it.set_day;
                    err = (nxt < 0) || (nxt > MAX_COUNT);
                end
            endcase
            if (!err && nxt != count) begin
                count = nxt;
                decode_count();
            end
            res.status = err;
            res.count  = DAY_BITS'(count);
            res.year   = YEAR_W'(cur_year);
            res.month  = MON_W'(cur_month);
            res.day    = MDAY_W'(cur_day);
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            fail_count++;
        endtask

        task check_result(logic status, logic [RES_W-1:0] data);
            t_day_result got, exp;
            got.status = status;
            got.count  = data[DAY_BITS-1:0];
            got.year   = data[YEAR_LSB +: YEAR_W];
            got.month  = data[MON_LSB +: MON_W];
            got.day    = data[MDAY_LSB +: MDAY_W];
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected: st %0d count %0d",
                                          got.status, got.count));
            end else begin
                exp = expected_q.pop_front();
                if (got !== exp)
                    report_mismatch($sformatf(
                        "got st %0d cnt %0d %0d-%0d-%0d, exp st %0d cnt %0d %0d-%0d-%0d",
                        got.status, got.count, got.year, got.month, got.day,
                        exp.status, exp.count, exp.year, exp.month, exp.day));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [IN_DATA_W-1:0] i_s_tdata;
    logic [CMD_W-1:0]     i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [RES_W-1:0]     o_m_tdata;
    logic [0:0]           o_m_tuser;

    calendar_scoreboard sb;
    int src_idle_pct;
    int snk_idle_pct;
    int quiet_cycles;

    day_count_calendar_engine_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_item word_of(t_cmd cmd, int amt, int y, int m, int d);
        t_item it;
        it.cmd       = cmd;
        it.amount    = AMT_W'(amt);
        it.set_year  = SYEAR_W'(y);
        it.set_month = MON_W'(m);
        it.set_day   = MDAY_W'(d);
        return it;
    endfunction

    // mostly small steps with the odd full-range amount, dates mostly near the epoch
    function automatic t_item random_word();
        t_item it;
        int    sel;
        it.cmd = t_cmd'($urandom_range(3));
        sel = $urandom_range(99);
        case (it.cmd)
            CMD_ADD_DAYS:
                it.amount = (sel < 80) ? AMT_W'(int'($urandom_range(6000)) - 3000)
                                       : AMT_W'($urandom);
            CMD_ADD_MONTHS:
                it.amount = (sel < 75) ? AMT_W'($urandom_range(60)) :
                            (sel < 90) ? AMT_W'(-int'($urandom_range(524288, 1))) :
                                         AMT_W'($urandom);
            CMD_ADD_YEARS:
                it.amount = (sel < 75) ? AMT_W'($urandom_range(30)) :
                            (sel < 90) ? AMT_W'(-int'($urandom_range(524288, 1))) :
                                         AMT_W'($urandom);
            default:
                it.amount = AMT_W'($urandom);
        endcase
        it.set_year  = ($urandom_range(99) < 80) ? SYEAR_W'($urandom_range(2400, 1970))
                                                 : SYEAR_W'($urandom_range(4095));
        it.set_month = ($urandom_range(99) < 90) ? MON_W'($urandom_range(12, 1))
                                                 : MON_W'($urandom_range(15));
        it.set_day   = MDAY_W'($urandom_range(31));
        return it;
    endfunction

    // entered and left just after a falling edge; valid stays up between back-to-back words
    task automatic send_word(t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = it.cmd;
        i_s_tdata  = '0;
        i_s_tdata[AMT_LSB +: AMT_W]     = it.amount;
        i_s_tdata[SYEAR_LSB +: SYEAR_W] = it.set_year;
        i_s_tdata[SMON_LSB +: MON_W]    = it.set_month;
        i_s_tdata[SDAY_LSB +: MDAY_W]   = it.set_day;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_command(it);
        @(negedge i_clk);
    endtask

    // hold the sender off until every result is back
    task automatic drain_results();
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver stalls at random
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_m_tready = ($urandom_range(99) >= snk_idle_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser[0], o_m_tdata);
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** day_count_calendar_engine_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int ph, k;
        sb = new();
        quiet_cycles = 0;
        src_idle_pct = 15;
        snk_idle_pct = 77;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = CMD_ADD_DAYS;
        i_m_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: range edges on days, overflow at the top, month overrun,
        // year steps either side of february and odd set fields
        send_word(word_of(CMD_ADD_DAYS, 0, 1970, 1, 1));
        send_word(word_of(CMD_ADD_DAYS, -1, 1970, 1, 1));
        send_word(word_of(CMD_ADD_DAYS, 524287, 1970, 1, 1));
        send_word(word_of(CMD_ADD_DAYS, -524288, 1970, 1, 1));
        send_word(word_of(CMD_ADD_DAYS, 524287, 1970, 1, 1));
        send_word(word_of(CMD_ADD_DAYS, 1, 1970, 1, 1));
        send_word(word_of(CMD_ADD_DAYS, 1, 1970, 1, 1));
        send_word(word_of(CMD_ADD_MONTHS, 524287, 1970, 1, 1));
        send_word(word_of(CMD_ADD_YEARS, 524287, 1970, 1, 1));
        send_word(word_of(CMD_SET_DATE, 0, 1970, 1, 0));
        send_word(word_of(CMD_SET_DATE, 0, 1970, 1, 1));
        send_word(word_of(CMD_SET_DATE, 0, 2000, 1, 31));
        send_word(word_of(CMD_ADD_MONTHS, 1, 1970, 1, 1));
        send_word(word_of(CMD_ADD_MONTHS, -524288, 1970, 1, 1));
        send_word(word_of(CMD_ADD_MONTHS, 0, 1970, 1, 1));
        send_word(word_of(CMD_SET_DATE, 0, 2000, 2, 29));
        send_word(word_of(CMD_ADD_YEARS, 1, 1970, 1, 1));
        send_word(word_of(CMD_SET_DATE, 0, 2003, 3, 1));
        send_word(word_of(CMD_ADD_YEARS, 1, 1970, 1, 1));
        send_word(word_of(CMD_ADD_YEARS, -3, 1970, 1, 1));
        send_word(word_of(CMD_SET_DATE, 0, 2010, 0, 5));
        send_word(word_of(CMD_SET_DATE, 0, 2010, 15, 31));
        send_word(word_of(CMD_SET_DATE, 0, 0, 2, 30));
        send_word(word_of(CMD_SET_DATE, 0, 4095, 12, 31));
        send_word(word_of(CMD_ADD_YEARS, 100, 1970, 1, 1));
        send_word(word_of(CMD_SET_DATE, 524287, 4095, 15, 31));
        send_word(word_of(CMD_ADD_DAYS, -524288, 1970, 1, 1));
        drain_results();

        // random: sender light and receiver heavy, then swapped, then no idling
        for (ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 77 : 0;
            snk_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 15 : 0;
            for (k = 0; k < 38; k++)
                send_word(random_word());
            drain_results();
        end

        repeat (3000) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("** day_count_calendar_engine_unit: PASSED **");
        else
            $display("** day_count_calendar_engine_unit: FAILED **");
        $finish;
    end

endmodule
